// ----- src/stq_pkg.sv -----
// Shared types and constants of the sorted timer delay queue.
package stq_pkg;

    // Default size of the timer pool.
    localparam int unsigned ENTRIES_DEF = 12;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned TASK_W = 8;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_QUERY = 2'd1,
        OP_DELAY = 2'd2,
        OP_UNTIL = 2'd3
    } t_op;

    // Result kind codes.
    typedef enum logic [1:0] {
        KIND_TIME   = 2'd0,
        KIND_WAKE   = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_FULL   = 2'd3
    } t_kind;

    // Input item.
    typedef struct packed {
        logic [1:0]        operation;
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] amount;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [1:0]        kind;
        logic [TASK_W-1:0] task_id_out;
        logic [TIME_W-1:0] time_value;
        logic              last;
    } t_out_item;

    // Contents of one timer cell.
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] deadline;
        logic [TASK_W-1:0] owner;
    } t_entry;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_cmd;

endpackage

// ----- src/stq_cell.sv -----
// One cell of the sorted timer chain: holds one timer and shifts with its neighbors.
module stq_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  stq_pkg::t_cell_cmd        i_cmd,
    input  logic [stq_pkg::TIME_W-1:0] i_cmp,
    input  stq_pkg::t_entry           i_new,
    input  stq_pkg::t_entry           i_left,
    input  logic                      i_left_le,
    input  stq_pkg::t_entry           i_right,
    output stq_pkg::t_entry           o_entry,
    output logic                      o_le
);

    logic                       r_valid;
    logic [stq_pkg::TIME_W-1:0] r_deadline;
    logic [stq_pkg::TASK_W-1:0] r_owner;
    stq_pkg::t_entry            n_entry;

    // A valid timer at or below the compare value stays ahead of it.
    assign o_le = r_valid && (r_deadline <= i_cmp);

    assign o_entry.valid    = r_valid;
    assign o_entry.deadline = r_deadline;
    assign o_entry.owner    = r_owner;

    // Insert keeps, takes the new timer, or shifts right; pop shifts left.
    always_comb begin
        n_entry = o_entry;
        if (i_cmd.insert) begin
            if (!o_le) begin
                if (i_left_le) begin
                    n_entry = i_new;
                end else begin
                    n_entry = i_left;
                end
            end
        end else if (i_cmd.pop) begin
            n_entry = i_right;
        end
    end

    // Valid flag is control state; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deadline <= n_entry.deadline;
        r_owner    <= n_entry.owner;
    end

endmodule

// ----- src/sorted_timer_delay_queue.sv -----
// Top level of the sorted timer delay queue: control, tick counter and cell chain.
//
// Input items arrive on i_in_valid / o_in_ready with payload i_in_item, and
// result items leave on o_out_valid / i_out_ready with payload o_out_item.
// A time query, delay or delay-until is answered through the output register:
// a delay lands in its sorted place in the cell chain, unless the pool is
// full, at the same edge that registers its result, so the result is on the
// output in the cycle after acceptance. A tick advances the count, then the
// head of the chain is popped once per released timer; the wake-up results
// leave in deadline order and the final one carries last. A tick with
// nothing due gives no result and frees the block. Outside ticks, a new item
// may be accepted every cycle while the output register is free or emptied.
// The input is taken only while no tick is draining and the output register
// is free or is being emptied; a stalled receiver holds the drain in place.
// Reset clears the tick count and empties the pool; the timer payloads are
// not cleared, as only valid cells are ever read.
module sorted_timer_delay_queue #(
    parameter int unsigned ENTRIES = stq_pkg::ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output stq_pkg::t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    t_state                     r_state, n_state;
    logic [stq_pkg::TIME_W-1:0] r_count, n_count;
    logic                       r_out_valid, n_out_valid;
    stq_pkg::t_out_item         r_out_item, n_out_item;

    stq_pkg::t_entry            cell_q [ENTRIES];
    logic                       cell_le [ENTRIES];
    stq_pkg::t_cell_cmd         cmd;
    stq_pkg::t_entry            new_entry;
    stq_pkg::t_entry            empty_entry;
    logic [stq_pkg::TIME_W-1:0] ins_deadline;
    logic [stq_pkg::TIME_W-1:0] cmp_value;
    logic                       accept;
    logic                       slot_free;
    logic                       pool_full;
    logic                       is_delay;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign accept     = i_in_valid && o_in_ready;
    assign pool_full  = cell_q[ENTRIES-1].valid;
    assign is_delay   = (i_in_item.operation == stq_pkg::OP_DELAY)
                     || (i_in_item.operation == stq_pkg::OP_UNTIL);

    // Deadline of a new timer: relative to the count or absolute.
    assign ins_deadline = (i_in_item.operation == stq_pkg::OP_DELAY)
                        ? r_count + i_in_item.amount : i_in_item.amount;

    // Cells compare against the count while draining, else the new deadline.
    assign cmp_value = (r_state == S_DRAIN) ? r_count : ins_deadline;

    assign new_entry.valid    = 1'b1;
    assign new_entry.deadline = ins_deadline;
    assign new_entry.owner    = i_in_item.task_id;

    assign empty_entry.valid    = 1'b0;
    assign empty_entry.deadline = '0;
    assign empty_entry.owner    = '0;

    // Chain commands: insert on an accepted delay while the pool is not full, pop on each wake-up sent.
    assign cmd.insert = accept && is_delay && !pool_full;
    assign cmd.pop    = (r_state == S_DRAIN) && cell_le[0] && slot_free;

    // Row of timer cells; cell 0 is the head, the earliest deadline.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        stq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (cmd),
            .i_cmp     (cmp_value),
            .i_new     (new_entry),
            .i_left    ((g == 0) ? empty_entry : cell_q[(g == 0) ? 0 : g-1]),
            .i_left_le ((g == 0) ? 1'b1 : cell_le[(g == 0) ? 0 : g-1]),
            .i_right   ((g == ENTRIES-1) ? empty_entry
                                         : cell_q[(g == ENTRIES-1) ? g : g+1]),
            .o_entry   (cell_q[g]),
            .o_le      (cell_le[g])
        );
    end

    // Control, tick counter and output register next values.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_item.operation)
                        stq_pkg::OP_TICK: begin
                            n_count = r_count + 1'b1;
                            n_state = S_DRAIN;
                        end
                        stq_pkg::OP_QUERY: begin
                            n_out_valid             = 1'b1;
                            n_out_item.kind         = stq_pkg::KIND_TIME;
                            n_out_item.task_id_out  = i_in_item.task_id;
                            n_out_item.time_value   = r_count;
                            n_out_item.last         = 1'b1;
                        end
                        default: begin
                            n_out_valid             = 1'b1;
                            n_out_item.kind         = pool_full ? stq_pkg::KIND_FULL
                                                                : stq_pkg::KIND_ACCEPT;
                            n_out_item.task_id_out  = i_in_item.task_id;
                            n_out_item.time_value   = r_count;
                            n_out_item.last         = 1'b1;
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                if (!cell_le[0]) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    n_out_valid            = 1'b1;
                    n_out_item.kind        = stq_pkg::KIND_WAKE;
                    n_out_item.task_id_out = cell_q[0].owner;
                    n_out_item.time_value  = r_count;
                    n_out_item.last        = !cell_le[1];
                    if (!cell_le[1]) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
